// ===== design/lsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsl_pkg;

   localparam int RAW_W       = 16;
   localparam int LUX_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int MODE_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // dividend is infrared << 10, one quotient bit per step
   localparam int RATIO_SHIFT = 10;
   localparam int DIV_STEPS   = RAW_W + RATIO_SHIFT;
   localparam int CH_W        = RAW_W + 4;
   localparam int COEF_W      = 10;
   localparam int PROD_W      = CH_W + COEF_W;
   localparam int LUX_SHIFT   = 14;

   localparam logic [RAW_W-1:0] CLIP_LIMIT  = 16'd65000;
   localparam logic [RAW_W-1:0] WINDOW_HIGH = 16'd63000;
   localparam logic [RAW_W-1:0] WINDOW_LOW  = 16'd500;
   localparam logic [PROD_W:0]  ROUND_HALF  = (PROD_W+1)'(1 << 13);

   localparam logic [MODE_W-1:0] MODE_AUTO       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIXED_LOW  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIXED_HIGH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_VALID   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISCARD = 2'd2;

   localparam logic CSR_IDX_GAIN_MODE = 1'b0;

   typedef enum logic [1:0] {
      KIND_CALC,
      KIND_ZERO,
      KIND_DISCARD
   } item_kind_type;

   typedef struct packed {
      logic [RAW_W-1:0] broadband;
      logic [RAW_W-1:0] infrared;
      logic             gain_high;
      item_kind_type    kind;
   } qentry_type;

   typedef struct packed {
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] m;
   } coef_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_COEF,
      BK_MULP,
      BK_MULN,
      BK_FIN,
      BK_DONE
   } back_state_type;

   function automatic coef_type lsl_coef(input logic [DIV_STEPS-1:0] ratio);
      coef_type c;
      priority if (ratio <= DIV_STEPS'(12'h040)) begin
         c.b = 10'h1F2; c.m = 10'h1BE;
      end else if (ratio <= DIV_STEPS'(12'h080)) begin
         c.b = 10'h214; c.m = 10'h2D1;
      end else if (ratio <= DIV_STEPS'(12'h0C0)) begin
         c.b = 10'h23F; c.m = 10'h37B;
      end else if (ratio <= DIV_STEPS'(12'h100)) begin
         c.b = 10'h270; c.m = 10'h3FE;
      end else if (ratio <= DIV_STEPS'(12'h138)) begin
         c.b = 10'h16F; c.m = 10'h1FC;
      end else if (ratio <= DIV_STEPS'(12'h19A)) begin
         c.b = 10'h0D2; c.m = 10'h0FB;
      end else if (ratio <= DIV_STEPS'(12'h29A)) begin
         c.b = 10'h018; c.m = 10'h012;
      end else begin
         c.b = '0; c.m = '0;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/lsl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsl_front
   import lsl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [RAW_W-1:0]      req_raw_broadband,
   input  wire logic [RAW_W-1:0]      req_raw_infrared,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready,
   input  wire logic                  q_full,
   output logic                       q_push,
   output qentry_type                 q_entry
);

   logic [MODE_W-1:0] gain_mode_ff, gain_mode_in;
   logic              auto_gain_high_ff, auto_gain_high_in;
   logic              skip_ff, skip_in;

   logic csr_hit;
   logic accept;
   logic fixed_mode;
   logic cur_hi;
   logic switch_gain;
   logic out_of_range;

   assign pready  = 1'b1;
   assign csr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_GAIN_MODE);
   assign prdata  = (paddr[2] == CSR_IDX_GAIN_MODE) ?
                    CSR_DATA_W'(gain_mode_ff) : '0;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign fixed_mode = (gain_mode_ff == MODE_FIXED_LOW) ||
                       (gain_mode_ff == MODE_FIXED_HIGH);
   assign cur_hi     = fixed_mode ? (gain_mode_ff == MODE_FIXED_HIGH) : auto_gain_high_ff;

   // gain flips only in the direction it can correct
   assign switch_gain = !fixed_mode && !skip_ff &&
                        (((req_raw_broadband < WINDOW_LOW) && !auto_gain_high_ff) ||
                         ((req_raw_broadband > WINDOW_HIGH) && auto_gain_high_ff));

   assign out_of_range = (req_raw_broadband > CLIP_LIMIT) ||
                         (req_raw_infrared > CLIP_LIMIT) ||
                         (req_raw_broadband == '0);

   always_comb begin
      gain_mode_in      = gain_mode_ff;
      auto_gain_high_in = auto_gain_high_ff;
      skip_in           = skip_ff;
      if (csr_hit) begin
         gain_mode_in      = pwdata[MODE_W-1:0];
         auto_gain_high_in = (pwdata[MODE_W-1:0] == MODE_FIXED_HIGH);
         skip_in           = 1'b0;
      end else if (accept) begin
         if (switch_gain) begin
            auto_gain_high_in = !auto_gain_high_ff;
            skip_in           = 1'b1;
         end else begin
            skip_in = 1'b0;
         end
      end
   end

   always_comb begin
      q_push            = accept;
      q_entry.broadband = req_raw_broadband;
      q_entry.infrared  = req_raw_infrared;
      if (switch_gain) begin
         q_entry.gain_high = !auto_gain_high_ff;
         q_entry.kind      = KIND_DISCARD;
      end else begin
         q_entry.gain_high = cur_hi;
         q_entry.kind      = out_of_range ? KIND_ZERO : KIND_CALC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_mode_ff      <= MODE_AUTO;
         auto_gain_high_ff <= 1'b0;
         skip_ff           <= 1'b0;
      end else begin
         gain_mode_ff      <= gain_mode_in;
         auto_gain_high_ff <= auto_gain_high_in;
         skip_ff           <= skip_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lsl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsl_queue
   import lsl_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire qentry_type  push_entry,
   output logic             full,
   input  wire logic        pop,
   output logic             not_empty,
   output qentry_type       head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qentry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lsl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsl_back
   import lsl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_not_empty,
   input  wire qentry_type       q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [LUX_W-1:0]      rsp_lux,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_gain_high
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   back_state_type state_ff, state_in;

   // working item
   logic [RAW_W-1:0]     b0_ff, b1_ff;
   logic                 hi_ff;
   item_kind_type        kind_ff;

   // divider
   logic [DIV_STEPS-1:0] dvd_ff;
   logic [RAW_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [RAW_W:0]       trial;
   logic                 qbit;

   coef_type             coef_ff;
   logic [PROD_W-1:0]    pos_ff, neg_ff;
   logic [LUX_W-1:0]     lux_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LUX_W-1:0]     rsp_lux_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_gain_ff;

   logic [CH_W-1:0]      ch0, ch1;
   logic [DIV_STEPS:0]   ratio_sum;
   logic [PROD_W-1:0]    diff;
   logic [PROD_W:0]      rounded;
   logic                 out_free;
   logic                 load_out;
   logic                 div_last;

   assign trial     = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign qbit      = (trial >= {1'b0, b0_ff});
   assign div_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign ch0       = hi_ff ? {4'b0, b0_ff} : {b0_ff, 4'b0};
   assign ch1       = hi_ff ? {4'b0, b1_ff} : {b1_ff, 4'b0};
   assign ratio_sum = {1'b0, dvd_ff} + (DIV_STEPS+1)'(1);
   assign diff      = (pos_ff > neg_ff) ? (pos_ff - neg_ff) : '0;
   assign rounded   = {1'b0, diff} + ROUND_HALF;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_not_empty) begin
               state_in = (q_head.kind == KIND_CALC) ? BK_DIV : BK_DONE;
            end
         end
         BK_DIV:  if (div_last) state_in = BK_COEF;
         BK_COEF: state_in = BK_MULP;
         BK_MULP: state_in = BK_MULN;
         BK_MULN: state_in = BK_FIN;
         BK_FIN:  state_in = BK_DONE;
         BK_DONE: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: q_pop    = q_not_empty;
         BK_DONE: load_out = out_free;
         default: begin
            q_pop    = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b0_ff   <= q_head.broadband;
         b1_ff   <= q_head.infrared;
         hi_ff   <= q_head.gain_high;
         kind_ff <= q_head.kind;
         dvd_ff  <= {q_head.infrared, RATIO_SHIFT'(0)};
         rem_ff  <= '0;
         cnt_ff  <= '0;
         lux_ff  <= '0;
      end
      if (state_ff == BK_DIV) begin
         rem_ff <= qbit ? RAW_W'(trial - {1'b0, b0_ff}) : trial[RAW_W-1:0];
         dvd_ff <= {dvd_ff[DIV_STEPS-2:0], qbit};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == BK_COEF) begin
         coef_ff <= lsl_coef(ratio_sum[DIV_STEPS:1]);
      end
      if (state_ff == BK_MULP) begin
         pos_ff <= ch0 * coef_ff.b;
      end
      if (state_ff == BK_MULN) begin
         neg_ff <= ch1 * coef_ff.m;
      end
      if (state_ff == BK_FIN) begin
         lux_ff <= rounded[LUX_SHIFT+LUX_W-1:LUX_SHIFT];
      end
      if (load_out) begin
         rsp_lux_ff  <= lux_ff;
         rsp_gain_ff <= hi_ff;
         if (kind_ff == KIND_DISCARD) begin
            rsp_status_ff <= STATUS_DISCARD;
         end else begin
            rsp_status_ff <= (lux_ff != '0) ? STATUS_VALID : STATUS_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lux       = rsp_lux_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_gain_high = rsp_gain_ff;

endmodule

`default_nettype wire

// ===== design/light_sensor_lux_with_autorange_top.sv =====
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | req_raw_broadband, req_raw_infrared
// rsp      | out       | rsp_valid/rsp_stall | rsp_lux, rsp_status, rsp_gain_high
// csr      | in/out    | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// an item that needs the lux formula passes through the back end in order: queue pop,
// 26 steps of the bit-serial ratio divider, coefficient pick, two multiplies,
// rounding and the output load; clipped, dark and discarded items go from pop to load.
// gain ranging is decided in the front end when the item is accepted.
// reset is synchronous and clears gain mode to automatic at 1x.
// a stalled result holds in the output register while the next item computes.
`timescale 1ns / 1ps
`default_nettype none

module light_sensor_lux_with_autorange_top
   import lsl_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [RAW_W-1:0]      req_raw_broadband,
   input  wire logic [RAW_W-1:0]      req_raw_infrared,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [LUX_W-1:0]           rsp_lux,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_gain_high,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_not_empty;
   qentry_type q_in;
   qentry_type q_head;

   lsl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_broadband (req_raw_broadband),
      .req_raw_infrared  (req_raw_infrared),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (q_in)
   );

   lsl_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   lsl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_lux       (rsp_lux),
      .rsp_status    (rsp_status),
      .rsp_gain_high (rsp_gain_high)
   );

endmodule

`default_nettype wire

// ===== design/lsl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsl_checker
   import lsl_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [LUX_W-1:0]    rsp_lux,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_gain_high
);

   // a discarded sample carries no lux
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DISCARD) |-> (rsp_lux == '0))
      else $error("discarded item with nonzero lux");

   // for items not discarded, status valid exactly when lux is nonzero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_DISCARD) |->
         ((rsp_status == STATUS_VALID) == (rsp_lux != '0)))
      else $error("status does not match lux");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_VALID) || (rsp_status == STATUS_ZERO) ||
                    (rsp_status == STATUS_DISCARD))
      else $error("unused status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lux) &&
                                 $stable(rsp_status) && $stable(rsp_gain_high))
      else $error("stalled item changed");

endmodule

bind light_sensor_lux_with_autorange_top lsl_checker u_lsl_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_lux       (rsp_lux),
   .rsp_status    (rsp_status),
   .rsp_gain_high (rsp_gain_high)
);

`default_nettype wire

// ===== tb/sv/light_sensor_lux_with_autorange_top_test.sv =====
`timescale 1ns / 1ps

module light_sensor_lux_with_autorange_top_test;
   import lsl_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 240;
   localparam int SETTLE_CYCLES  = 40;

   localparam logic [CSR_ADDR_W-1:0] GAIN_MODE_ADDR = CSR_ADDR_W'(4 * CSR_IDX_GAIN_MODE);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR     = CSR_ADDR_W'(4);
   localparam logic [MODE_W-1:0]     MODE_SPARE     = 2'd3;

   typedef struct packed {
      logic [LUX_W-1:0]    lux;
      logic [STATUS_W-1:0] status;
      logic                gain_high;
   } lux_reading_type;

   typedef struct {
      bit                    do_write;
      logic [CSR_ADDR_W-1:0] addr;
      logic [MODE_W-1:0]     mode;
      logic [RAW_W-1:0]      broadband;
      logic [RAW_W-1:0]      infrared;
      bit                    known;
      lux_reading_type       want;
   } bench_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [RAW_W-1:0]      req_raw_broadband = '0;
   logic [RAW_W-1:0]      req_raw_infrared = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LUX_W-1:0]      rsp_lux;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_gain_high;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state
   logic [MODE_W-1:0] cfg_mode = MODE_AUTO;
   logic              gain_auto = 1'b0;
   logic              skip_next = 1'b0;

   lux_reading_type pending_readings[$];
   bench_row_type   bench_rows[$];
   int              bad_count = 0;
   int              idle_cycles = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   bit              hold_go = 1'b0;
   int              hold_left = 0;

   light_sensor_lux_with_autorange_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_broadband (req_raw_broadband),
      .req_raw_infrared  (req_raw_infrared),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lux           (rsp_lux),
      .rsp_status        (rsp_status),
      .rsp_gain_high     (rsp_gain_high),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [LUX_W-1:0] lux_formula(input logic [RAW_W-1:0] b0,
                                                    input logic [RAW_W-1:0] b1,
                                                    input logic hi);
      longint unsigned c0, c1, ratio, kb, km, pos, neg, t;
      if (b0 > CLIP_LIMIT || b1 > CLIP_LIMIT) return '0;
      c0 = hi ? b0 : (longint'(b0) << 4);
      c1 = hi ? b1 : (longint'(b1) << 4);
      ratio = (c0 != 0) ? ((c1 << 10) / c0) : 0;
      ratio = (ratio + 1) >> 1;
      if (ratio <= 'h040) begin
         kb = 'h1F2; km = 'h1BE;
      end else if (ratio <= 'h080) begin
         kb = 'h214; km = 'h2D1;
      end else if (ratio <= 'h0C0) begin
         kb = 'h23F; km = 'h37B;
      end else if (ratio <= 'h100) begin
         kb = 'h270; km = 'h3FE;
      end else if (ratio <= 'h138) begin
         kb = 'h16F; km = 'h1FC;
      end else if (ratio <= 'h19A) begin
         kb = 'h0D2; km = 'h0FB;
      end else if (ratio <= 'h29A) begin
         kb = 'h018; km = 'h012;
      end else begin
         kb = 0; km = 0;
      end
      pos = c0 * kb;
      neg = c1 * km;
      t = (pos > neg) ? (pos - neg) : 0;
      t = (t + (1 << 13)) >> 14;
      return t[LUX_W-1:0];
   endfunction

   // advances the gain ranging state by one reading
   function automatic lux_reading_type predict_reading(input logic [RAW_W-1:0] b0,
                                                       input logic [RAW_W-1:0] b1);
      lux_reading_type r;
      logic            hi;
      if (cfg_mode == MODE_FIXED_LOW || cfg_mode == MODE_FIXED_HIGH) begin
         hi = (cfg_mode == MODE_FIXED_HIGH);
         skip_next = 1'b0;
      end else begin
         hi = gain_auto;
         if (!skip_next && ((b0 < WINDOW_LOW && !hi) || (b0 > WINDOW_HIGH && hi))) begin
            gain_auto = !hi;
            skip_next = 1'b1;
            r.lux = '0;
            r.status = STATUS_DISCARD;
            r.gain_high = gain_auto;
            return r;
         end
         skip_next = 1'b0;
      end
      r.lux = lux_formula(b0, b1, hi);
      r.status = (r.lux != 0) ? STATUS_VALID : STATUS_ZERO;
      r.gain_high = hi;
      return r;
   endfunction

   task automatic note_bad(input string what);
      if (bad_count < 10) $display("mismatch: %s", what);
      bad_count++;
   endtask

   always @(posedge clock) begin
      lux_reading_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               note_bad($sformatf("unexpected item lux=%0d status=%0d gain=%0d",
                                  rsp_lux, rsp_status, rsp_gain_high));
            end else begin
               want = pending_readings.pop_front();
               if (rsp_lux !== want.lux || rsp_status !== want.status ||
                   rsp_gain_high !== want.gain_high)
                  note_bad($sformatf("lux %0d/%0d status %0d/%0d gain %0d/%0d (exp/got)",
                                     want.lux, rsp_lux, want.status, rsp_status,
                                     want.gain_high, rsp_gain_high));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: random stall, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == GAIN_MODE_ADDR) begin
         cfg_mode = data[MODE_W-1:0];
         gain_auto = (cfg_mode == MODE_FIXED_HIGH);
         skip_next = 1'b0;
      end
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic csr_check_mode();
      psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = GAIN_MODE_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(cfg_mode))
         note_bad($sformatf("gain_mode read %0d, exp %0d", prdata, cfg_mode));
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   task automatic set_mode(input logic [CSR_ADDR_W-1:0] addr, input logic [MODE_W-1:0] m);
      wait_drained();
      csr_write(addr, CSR_DATA_W'(m));
      csr_check_mode();
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [RAW_W-1:0] b0, input logic [RAW_W-1:0] b1,
                            input bit known, input lux_reading_type typed);
      lux_reading_type pred;
      pred = predict_reading(b0, b1);
      pending_readings.push_back(known ? typed : pred);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_raw_broadband = b0;
      req_raw_infrared = b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic add_row(input bit do_write, input logic [CSR_ADDR_W-1:0] addr,
                          input logic [MODE_W-1:0] m, input int b0, input int b1,
                          input bit known, input int lux, input logic [STATUS_W-1:0] st,
                          input logic g);
      bench_row_type row;
      row.do_write = do_write;
      row.addr = addr;
      row.mode = m;
      row.broadband = RAW_W'(b0);
      row.infrared = RAW_W'(b1);
      row.known = known;
      row.want.lux = LUX_W'(lux);
      row.want.status = st;
      row.want.gain_high = g;
      bench_rows.push_back(row);
   endtask

   task automatic pick_pair(output logic [RAW_W-1:0] b0, output logic [RAW_W-1:0] b1);
      int unsigned k;
      int unsigned prod;
      k = $urandom_range(0, 9);
      case (k)
         0: begin
            case ($urandom_range(0, 11))
               0: b0 = 0;
               1: b0 = 1;
               2: b0 = 499;
               3: b0 = 500;
               4: b0 = 501;
               5: b0 = 62999;
               6: b0 = 63000;
               7: b0 = 63001;
               8: b0 = 64999;
               9: b0 = 65000;
               10: b0 = 65001;
               default: b0 = 65535;
            endcase
         end
         1: b0 = RAW_W'($urandom_range(0, 499));
         2: b0 = RAW_W'($urandom_range(63001, 65535));
         default: b0 = RAW_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
      endcase
      if ($urandom_range(0, 3) == 0) begin
         b1 = RAW_W'($urandom_range(0, 65535));
      end else begin
         // infrared as a fraction of broadband, spread over all coefficient bands
         prod = (b0 * $urandom_range(0, 1400)) >> 10;
         b1 = (prod > 65535) ? 16'hFFFF : RAW_W'(prod);
      end
   endtask

   initial begin
      logic [RAW_W-1:0]  b0, b1;
      logic [MODE_W-1:0] m;
      lux_reading_type   none;
      none = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // automatic ranging from reset at 1x
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 0, 0, 1, 0, STATUS_DISCARD, 1);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 65535, 65535, 1, 0, STATUS_ZERO, 1);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 65535, 0, 1, 0, STATUS_DISCARD, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 65001, 0, 1, 0, STATUS_ZERO, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 1000, 100, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 63000, 0, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 499, 499, 1, 0, STATUS_DISCARD, 1);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 499, 0, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 500, 0, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_AUTO, 63001, 1000, 1, 0, STATUS_DISCARD, 0);
      // fixed 1x: zero broadband, clip limit edges, ratio out of range
      add_row(1, GAIN_MODE_ADDR, MODE_FIXED_LOW, 0, 0, 1, 0, STATUS_ZERO, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_LOW, 65000, 65000, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_LOW, 65000, 0, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_LOW, 1, 65000, 1, 0, STATUS_ZERO, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_LOW, 0, 65000, 1, 0, STATUS_ZERO, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_LOW, 1000, 65001, 1, 0, STATUS_ZERO, 0);
      // fixed 16x: no window check, band edges
      add_row(1, GAIN_MODE_ADDR, MODE_FIXED_HIGH, 0, 0, 1, 0, STATUS_ZERO, 1);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_HIGH, 65535, 0, 1, 0, STATUS_ZERO, 1);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_HIGH, 1024, 128, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_HIGH, 1024, 1336, 0, 0, STATUS_VALID, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_FIXED_HIGH, 40000, 10000, 0, 0, STATUS_VALID, 0);
      // unused mode value acts as automatic, starting at 1x
      add_row(1, GAIN_MODE_ADDR, MODE_SPARE, 100, 0, 1, 0, STATUS_DISCARD, 1);
      add_row(0, GAIN_MODE_ADDR, MODE_SPARE, 20000, 5000, 0, 0, STATUS_VALID, 0);
      // write to an unmapped register must leave automatic ranging alone
      add_row(1, SPARE_ADDR, MODE_FIXED_HIGH, 65535, 0, 1, 0, STATUS_DISCARD, 0);
      add_row(0, GAIN_MODE_ADDR, MODE_SPARE, 16'hAAAA, 16'h5555, 0, 0, STATUS_VALID, 0);

      foreach (bench_rows[i]) begin
         if (bench_rows[i].do_write) set_mode(bench_rows[i].addr, bench_rows[i].mode);
         send_item(bench_rows[i].broadband, bench_rows[i].infrared,
                   bench_rows[i].known, bench_rows[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         m = MODE_W'((ph + ph / 4) % 4);
         set_mode(GAIN_MODE_ADDR, m);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         // long receiver hold-off while items keep coming, fills the block
         if (ph == 0) hold_go = 1'b1;
         repeat (PHASE_ITEMS) begin
            pick_pair(b0, b1);
            send_item(b0, b1, 0, none);
         end
      end

      req_valid = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (bad_count == 0 && pending_readings.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
